### design/ffpa_pkg.sv
`default_nettype none
package ffpa_pkg;

  // allocator geometry
  localparam int unsigned ALIGN_BYTES  = 8;
  localparam int unsigned HEADER_BYTES = 32;
  localparam int unsigned MAX_BLOCKS   = 2048;

  localparam int unsigned AddrW = $clog2(MAX_BLOCKS);
  localparam int unsigned CntW  = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned SizeW = 17;
  localparam int unsigned PosW  = 18;
  localparam int unsigned EntW  = SizeW + 1;

  localparam logic [SizeW-1:0] POOL_MIN = 17'd64;
  localparam logic [SizeW-1:0] POOL_MAX = 17'd65536;

  // result status codes
  localparam logic [2:0] ST_ALLOC   = 3'd0;
  localparam logic [2:0] ST_NOFIT   = 3'd1;
  localparam logic [2:0] ST_FREED   = 3'd2;
  localparam logic [2:0] ST_NULL    = 3'd3;
  localparam logic [2:0] ST_NOBLOCK = 3'd4;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_INIT,
    CMD_LOAD,
    CMD_READ,
    CMD_ADV,
    CMD_TAKE,
    CMD_SPLIT_START,
    CMD_SH_RD,
    CMD_SH_WR,
    CMD_SPLIT_HI,
    CMD_SPLIT_LO,
    CMD_FREE_WR,
    CMD_MISS,
    CMD_NULL,
    CMD_OUT
  } cmd_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_CHK,
    S_SHRD,
    S_SHWR,
    S_SPLIT_LO,
    S_FIN
  } state_e;

  typedef struct packed {
    logic init_pend;
    logic in_null;
    logic op_free;
    logic at_end;
    logic fit;
    logic split_ok;
    logic match;
    logic past;
    logic shift_more;
    logic out_busy;
  } dp_status_t;

endpackage
`default_nettype wire

### design/first_fit_pool_allocator_top.sv
`default_nettype none
// First-fit pool allocator. An allocate walks the block table from the start,
// with one block table RAM read and one check per block; a split then moves
// every later entry up by one, with a read and a write per entry through the
// single RAM port pair, so the walk and the shift together cover the table
// once. A free walks the same way until the offset is matched or passed or
// the table ends. A null free goes straight to its result without a walk. One
// item is in work at a time; the result register holds a finished result
// while the next item is accepted. After reset or a pool_size write, the
// first table entry is rewritten before the next item is taken.
module first_fit_pool_allocator_top (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic [ffpa_pkg::SizeW-1:0]  cfg_pool_size_i,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic                        operation_i,
  input  wire logic [15:0]                 request_size_i,
  input  wire logic [15:0]                 free_offset_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic      [2:0]                  status_o,
  output logic      [15:0]                 user_offset_o,
  output logic      [ffpa_pkg::SizeW-1:0]  granted_size_o
);

  ffpa_pkg::cmd_e       cmd;
  ffpa_pkg::dp_status_t st;

  assign cfg_ready_o = 1'b1;

  ffpa_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .st_i      (st),
    .cmd_o     (cmd)
  );

  ffpa_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .st_o           (st),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_pool_size_i(cfg_pool_size_i),
    .operation_i    (operation_i),
    .request_size_i (request_size_i),
    .free_offset_i  (free_offset_i),
    .out_ready_i    (out_ready_i),
    .out_valid_o    (out_valid_o),
    .status_o       (status_o),
    .user_offset_o  (user_offset_o),
    .granted_size_o (granted_size_o)
  );

  // one item in work at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while an item is in work");

  // a pool write rebuilds the table before the next item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |=> !in_ready_o)
    else $error("input taken before table rebuild");

  // delivered status is a defined code
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o <= ffpa_pkg::ST_NOBLOCK))
    else $error("undefined result status");

endmodule
`default_nettype wire

### design/ffpa_ram.sv
`default_nettype none
module ffpa_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

### design/ffpa_datapath.sv
`default_nettype none
module ffpa_datapath (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire ffpa_pkg::cmd_e              cmd_i,
  output ffpa_pkg::dp_status_t             st_o,
  input  wire logic                        cfg_valid_i,
  input  wire logic [ffpa_pkg::SizeW-1:0]  cfg_pool_size_i,
  input  wire logic                        operation_i,
  input  wire logic [15:0]                 request_size_i,
  input  wire logic [15:0]                 free_offset_i,
  input  wire logic                        out_ready_i,
  output logic                             out_valid_o,
  output logic      [2:0]                  status_o,
  output logic      [15:0]                 user_offset_o,
  output logic      [ffpa_pkg::SizeW-1:0]  granted_size_o
);

  localparam int unsigned AddrW = ffpa_pkg::AddrW;
  localparam int unsigned CntW  = ffpa_pkg::CntW;
  localparam int unsigned SizeW = ffpa_pkg::SizeW;
  localparam int unsigned PosW  = ffpa_pkg::PosW;
  localparam int unsigned EntW  = ffpa_pkg::EntW;
  localparam logic [SizeW-1:0] Hdr = SizeW'(ffpa_pkg::HEADER_BYTES);
  localparam logic [SizeW-1:0] AlignM1 = SizeW'(ffpa_pkg::ALIGN_BYTES - 1);
  localparam logic [CntW-1:0] MaxCnt = CntW'(ffpa_pkg::MAX_BLOCKS);

  logic [SizeW-1:0] pool_q;
  logic             init_q;
  logic [CntW-1:0]  count_q;
  logic [CntW-1:0]  idx_q, j_q;
  logic [PosW-1:0]  pos_q;
  logic [SizeW-1:0] need_q, rest_q;
  logic             op_q;
  logic [15:0]      foff_q;
  logic [2:0]       res_status_q;
  logic [15:0]      res_off_q;
  logic [SizeW-1:0] res_size_q;

  logic             we, re;
  logic [AddrW-1:0] waddr, raddr;
  logic [EntW-1:0]  wdata, rdata;

  ffpa_ram #(.Width(EntW), .Depth(ffpa_pkg::MAX_BLOCKS)) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // current entry fields and derived values
  logic [SizeW-1:0] cur_size;
  logic             cur_free;
  logic [PosW-1:0]  payload;
  logic [SizeW-1:0] rest;
  logic [SizeW-1:0] need;
  logic [SizeW-1:0] req_sum;
  logic [SizeW-1:0] cfg_clamped;

  assign cur_size = rdata[SizeW-1:0];
  assign cur_free = rdata[EntW-1];
  assign payload  = pos_q + PosW'(Hdr);
  assign rest     = cur_size - need_q;
  assign req_sum  = SizeW'(request_size_i) + AlignM1;
  assign need     = SizeW'((req_sum / ffpa_pkg::ALIGN_BYTES) * ffpa_pkg::ALIGN_BYTES);

  always_comb begin
    cfg_clamped = cfg_pool_size_i;
    if (cfg_pool_size_i < ffpa_pkg::POOL_MIN) begin
      cfg_clamped = ffpa_pkg::POOL_MIN;
    end else if (cfg_pool_size_i > ffpa_pkg::POOL_MAX) begin
      cfg_clamped = ffpa_pkg::POOL_MAX;
    end
  end

  // status toward the controller
  always_comb begin
    st_o.init_pend  = init_q;
    st_o.in_null    = operation_i && (free_offset_i == 16'd0);
    st_o.op_free    = op_q;
    st_o.at_end     = (idx_q == count_q);
    st_o.fit        = cur_free && (cur_size >= need_q);
    st_o.split_ok   = (rest > Hdr) && (count_q < MaxCnt);
    st_o.match      = (payload == PosW'(foff_q));
    st_o.past       = (payload > PosW'(foff_q));
    st_o.shift_more = ({1'b0, j_q} > ({1'b0, idx_q} + (CntW+1)'(1)));
    st_o.out_busy   = out_valid_o && !out_ready_i;
  end

  // memory port control
  always_comb begin
    we    = 1'b0;
    re    = 1'b0;
    waddr = idx_q[AddrW-1:0];
    raddr = idx_q[AddrW-1:0];
    wdata = {1'b0, cur_size};
    case (cmd_i)
      ffpa_pkg::CMD_INIT: begin
        we    = 1'b1;
        waddr = '0;
        wdata = {1'b1, pool_q - Hdr};
      end
      ffpa_pkg::CMD_READ: begin
        re = 1'b1;
      end
      ffpa_pkg::CMD_TAKE: begin
        we = 1'b1;
      end
      ffpa_pkg::CMD_FREE_WR: begin
        we    = 1'b1;
        wdata = {1'b1, cur_size};
      end
      ffpa_pkg::CMD_SH_RD: begin
        re    = 1'b1;
        raddr = AddrW'(j_q - CntW'(1));
      end
      ffpa_pkg::CMD_SH_WR: begin
        we    = 1'b1;
        waddr = j_q[AddrW-1:0];
        wdata = rdata;
      end
      ffpa_pkg::CMD_SPLIT_HI: begin
        we    = 1'b1;
        waddr = AddrW'(idx_q + CntW'(1));
        wdata = {1'b1, rest_q - Hdr};
      end
      ffpa_pkg::CMD_SPLIT_LO: begin
        we    = 1'b1;
        wdata = {1'b0, need_q};
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_q      <= ffpa_pkg::POOL_MAX;
      init_q      <= 1'b1;
      count_q     <= CntW'(1);
      out_valid_o <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        pool_q <= cfg_clamped;
        init_q <= 1'b1;
      end else if (cmd_i == ffpa_pkg::CMD_INIT) begin
        init_q <= 1'b0;
      end
      if (cmd_i == ffpa_pkg::CMD_INIT) begin
        count_q <= CntW'(1);
      end else if (cmd_i == ffpa_pkg::CMD_SPLIT_LO) begin
        count_q <= count_q + CntW'(1);
      end
      if (cmd_i == ffpa_pkg::CMD_OUT) begin
        out_valid_o <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  // walk and result registers
  always_ff @(posedge clk_i) begin
    case (cmd_i)
      ffpa_pkg::CMD_LOAD: begin
        op_q         <= operation_i;
        foff_q       <= free_offset_i;
        need_q       <= need;
        idx_q        <= '0;
        pos_q        <= '0;
        res_off_q    <= '0;
        res_size_q   <= '0;
      end
      ffpa_pkg::CMD_ADV: begin
        pos_q <= pos_q + PosW'(Hdr) + PosW'(cur_size);
        idx_q <= idx_q + CntW'(1);
      end
      ffpa_pkg::CMD_TAKE: begin
        res_status_q <= ffpa_pkg::ST_ALLOC;
        res_off_q    <= payload[15:0];
        res_size_q   <= need_q;
      end
      ffpa_pkg::CMD_SPLIT_START: begin
        rest_q       <= rest;
        j_q          <= count_q;
        res_status_q <= ffpa_pkg::ST_ALLOC;
        res_off_q    <= payload[15:0];
        res_size_q   <= need_q;
      end
      ffpa_pkg::CMD_SH_WR: begin
        j_q <= j_q - CntW'(1);
      end
      ffpa_pkg::CMD_FREE_WR: begin
        res_status_q <= ffpa_pkg::ST_FREED;
        res_size_q   <= cur_size;
      end
      ffpa_pkg::CMD_MISS: begin
        res_status_q <= op_q ? ffpa_pkg::ST_NOBLOCK : ffpa_pkg::ST_NOFIT;
      end
      ffpa_pkg::CMD_NULL: begin
        res_status_q <= ffpa_pkg::ST_NULL;
        res_off_q    <= '0;
        res_size_q   <= '0;
      end
      ffpa_pkg::CMD_OUT: begin
        status_o       <= res_status_q;
        user_offset_o  <= res_off_q;
        granted_size_o <= res_size_q;
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

### design/ffpa_ctrl.sv
`default_nettype none
module ffpa_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire ffpa_pkg::dp_status_t st_i,
  output ffpa_pkg::cmd_e            cmd_o
);

  ffpa_pkg::state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ffpa_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = ffpa_pkg::CMD_NONE;
    in_ready_o = 1'b0;
    case (state_q)
      ffpa_pkg::S_IDLE: begin
        if (st_i.init_pend) begin
          cmd_o = ffpa_pkg::CMD_INIT;
        end else begin
          in_ready_o = 1'b1;
          if (in_valid_i) begin
            if (st_i.in_null) begin
              cmd_o   = ffpa_pkg::CMD_NULL;
              state_d = ffpa_pkg::S_FIN;
            end else begin
              cmd_o   = ffpa_pkg::CMD_LOAD;
              state_d = ffpa_pkg::S_RD;
            end
          end
        end
      end
      ffpa_pkg::S_RD: begin
        if (st_i.at_end) begin
          cmd_o   = ffpa_pkg::CMD_MISS;
          state_d = ffpa_pkg::S_FIN;
        end else begin
          cmd_o   = ffpa_pkg::CMD_READ;
          state_d = ffpa_pkg::S_CHK;
        end
      end
      ffpa_pkg::S_CHK: begin
        if (!st_i.op_free) begin
          if (!st_i.fit) begin
            cmd_o   = ffpa_pkg::CMD_ADV;
            state_d = ffpa_pkg::S_RD;
          end else if (st_i.split_ok) begin
            cmd_o   = ffpa_pkg::CMD_SPLIT_START;
            state_d = ffpa_pkg::S_SHRD;
          end else begin
            cmd_o   = ffpa_pkg::CMD_TAKE;
            state_d = ffpa_pkg::S_FIN;
          end
        end else if (st_i.match) begin
          cmd_o   = ffpa_pkg::CMD_FREE_WR;
          state_d = ffpa_pkg::S_FIN;
        end else if (st_i.past) begin
          cmd_o   = ffpa_pkg::CMD_MISS;
          state_d = ffpa_pkg::S_FIN;
        end else begin
          cmd_o   = ffpa_pkg::CMD_ADV;
          state_d = ffpa_pkg::S_RD;
        end
      end
      // move the tail up one entry to open a slot
      ffpa_pkg::S_SHRD: begin
        if (st_i.shift_more) begin
          cmd_o   = ffpa_pkg::CMD_SH_RD;
          state_d = ffpa_pkg::S_SHWR;
        end else begin
          cmd_o   = ffpa_pkg::CMD_SPLIT_HI;
          state_d = ffpa_pkg::S_SPLIT_LO;
        end
      end
      ffpa_pkg::S_SHWR: begin
        cmd_o   = ffpa_pkg::CMD_SH_WR;
        state_d = ffpa_pkg::S_SHRD;
      end
      ffpa_pkg::S_SPLIT_LO: begin
        cmd_o   = ffpa_pkg::CMD_SPLIT_LO;
        state_d = ffpa_pkg::S_FIN;
      end
      ffpa_pkg::S_FIN: begin
        if (!st_i.out_busy) begin
          cmd_o   = ffpa_pkg::CMD_OUT;
          state_d = ffpa_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = ffpa_pkg::S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

### dv/first_fit_pool_allocator_top_test.sv
`timescale 1ns / 1ps
module first_fit_pool_allocator_top_test;
  import ffpa_pkg::*;

  localparam int unsigned CycleLimit = 3_000_000;
  localparam int unsigned HoldCycles = 400;

  typedef struct packed {
    logic [2:0]       status;
    logic [15:0]      user_offset;
    logic [SizeW-1:0] granted_size;
  } alloc_result_t;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_valid_i;
  logic             cfg_ready_o;
  logic [SizeW-1:0] cfg_pool_size_i;
  logic             in_valid_i;
  logic             in_ready_o;
  logic             operation_i;
  logic [15:0]      request_size_i;
  logic [15:0]      free_offset_i;
  logic             out_valid_o;
  logic             out_ready_i;
  logic [2:0]       status_o;
  logic [15:0]      user_offset_o;
  logic [SizeW-1:0] granted_size_o;

  first_fit_pool_allocator_top i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_pool_size_i(cfg_pool_size_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .operation_i    (operation_i),
    .request_size_i (request_size_i),
    .free_offset_i  (free_offset_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .user_offset_o  (user_offset_o),
    .granted_size_o (granted_size_o)
  );

  // mirror of the block table
  int unsigned   pool_bytes;
  int unsigned   blk_size [MAX_BLOCKS];
  bit            blk_free [MAX_BLOCKS];
  int unsigned   blk_count;
  logic [15:0]   live_offsets[$];
  alloc_result_t expected_q[$];

  int unsigned err_cnt;
  int unsigned cycle_cnt;
  int unsigned burst_left;
  int unsigned stall_pct;
  int unsigned hold_cnt;
  bit          hold_req;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic void table_clear();
    for (int i = 0; i < MAX_BLOCKS; i++) begin
      blk_size[i] = 0;
      blk_free[i] = 1'b0;
    end
    blk_size[0] = (pool_bytes - HEADER_BYTES) & 32'h1FFFF;
    blk_free[0] = 1'b1;
    blk_count = 1;
    live_offsets.delete();
  endfunction

  function automatic void pool_write(logic [SizeW-1:0] v);
    int unsigned p;
    p = v;
    if (p < 64) p = 64;
    if (p > 65536) p = 65536;
    pool_bytes = p;
    table_clear();
  endfunction

  // first fit with split, or free by payload offset
  function automatic alloc_result_t pool_step(bit op, logic [15:0] req, logic [15:0] foff);
    alloc_result_t r;
    int unsigned need, rest, pos, p;
    r = '0;
    pos = 0;
    if (op == 1'b0) begin
      need = ((int'(req) + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
      r.status = ST_NOFIT;
      for (int i = 0; i < blk_count; i++) begin
        if (blk_free[i] && blk_size[i] >= need) begin
          rest = blk_size[i] - need;
          if (rest > HEADER_BYTES && blk_count < MAX_BLOCKS) begin
            for (int j = blk_count; j > i + 1; j--) begin
              blk_size[j] = blk_size[j-1];
              blk_free[j] = blk_free[j-1];
            end
            blk_size[i+1] = rest - HEADER_BYTES;
            blk_free[i+1] = 1'b1;
            blk_size[i] = need;
            blk_count++;
          end
          blk_free[i] = 1'b0;
          r.status = ST_ALLOC;
          r.user_offset = 16'(pos + HEADER_BYTES);
          r.granted_size = SizeW'(need);
          live_offsets.push_back(r.user_offset);
          break;
        end
        pos += HEADER_BYTES + blk_size[i];
      end
    end else if (foff == 16'd0) begin
      r.status = ST_NULL;
    end else begin
      r.status = ST_NOBLOCK;
      for (int i = 0; i < blk_count; i++) begin
        p = pos + HEADER_BYTES;
        if (p == foff) begin
          blk_free[i] = 1'b1;
          r.status = ST_FREED;
          r.granted_size = SizeW'(blk_size[i]);
          break;
        end
        if (p > foff) break;
        pos += HEADER_BYTES + blk_size[i];
      end
    end
    return r;
  endfunction

  task automatic report(string what, int unsigned got, int unsigned want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    err_cnt++;
  endtask

  // one input transfer, then maybe a gap between bursts
  task automatic send_item(bit op, logic [15:0] req, logic [15:0] foff);
    in_valid_i     <= 1'b1;
    operation_i    <= op;
    request_size_i <= req;
    free_offset_i  <= foff;
    do @(posedge clk_i); while (!in_ready_o);
    expected_q.push_back(pool_step(op, req, foff));
    @(negedge clk_i);
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
      burst_left = $urandom_range(0, 12);
    end else begin
      burst_left--;
    end
  endtask

  // stop sending until every result is back
  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic set_pool(logic [SizeW-1:0] v);
    drain();
    cfg_valid_i     <= 1'b1;
    cfg_pool_size_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    pool_write(v);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    repeat (2) @(negedge clk_i);
  endtask

  task automatic test_reset_pool();
    send_item(1'b0, 16'd1, 16'd0);
    send_item(1'b0, 16'd0, 16'd0);
    send_item(1'b0, 16'd100, 16'd0);
    send_item(1'b1, 16'd0, 16'd32);
    send_item(1'b0, 16'd8, 16'd0);
  endtask

  task automatic test_extremes();
    set_pool(17'd65536);
    send_item(1'b0, 16'hFFFF, 16'hFFFF);
    send_item(1'b0, 16'd65504, 16'd0);
    send_item(1'b1, 16'h0000, 16'd32);
    send_item(1'b1, 16'h0000, 16'd32);
    send_item(1'b0, 16'd65497, 16'd0);
    send_item(1'b1, 16'hFFFF, 16'd0);
    send_item(1'b1, 16'd0, 16'hFFFF);
    send_item(1'b1, 16'd0, 16'd33);
    send_item(1'b1, 16'd0, 16'd8);
    send_item(1'b0, 16'd0, 16'd0);
    send_item(1'b0, 16'd0, 16'd0);
    send_item(1'b1, 16'd0, 16'd64);
    send_item(1'b0, 16'd0, 16'd0);
  endtask

  task automatic test_pool_settings();
    set_pool(17'd0);
    send_item(1'b0, 16'd32, 16'd0);
    send_item(1'b0, 16'd0, 16'd0);
    send_item(1'b1, 16'd0, 16'd32);
    set_pool(17'h1FFFF);
    send_item(1'b0, 16'hFFFF, 16'd0);
    send_item(1'b0, 16'd65500, 16'd0);
    set_pool(17'd64);
    send_item(1'b0, 16'd25, 16'd0);
    send_item(1'b0, 16'd1, 16'd0);
    set_pool(17'd100);
    send_item(1'b0, 16'd0, 16'd0);
    send_item(1'b0, 16'd0, 16'd0);
  endtask

  // receiver holds off while the sender keeps offering
  task automatic test_backpressure();
    set_pool(17'd4096);
    hold_req = 1'b1;
    for (int i = 0; i < 8; i++) send_item(1'b0, 16'($urandom_range(0, 64)), 16'd0);
    drain();
  endtask

  task automatic random_item();
    int unsigned pick, k;
    logic [15:0] req, foff;
    pick = $urandom_range(0, 99);
    req  = 16'($urandom());
    foff = 16'($urandom());
    if (live_offsets.size() != 0 && pick < 40) begin
      k = $urandom_range(0, live_offsets.size() - 1);
      if (pick < 28) begin
        foff = live_offsets[k];
        live_offsets.delete(k);
      end else if (pick < 32) foff = 16'd0;
      else if (pick < 36) foff = live_offsets[k] + 16'd8;
      send_item(1'b1, req, foff);
    end else begin
      if (pick < 75) req = 16'($urandom_range(0, 200));
      else if (pick < 92) req = 16'($urandom_range(0, 2000));
      send_item(1'b0, req, foff);
    end
  endtask

  task automatic test_random();
    logic [SizeW-1:0] sizes[6];
    sizes = '{17'd65536, 17'd512, 17'($urandom()), 17'd2048, 17'($urandom_range(64, 65536)), 17'd64};
    foreach (sizes[p]) begin
      set_pool(sizes[p]);
      stall_pct = $urandom_range(0, 3) * 20;
      for (int i = 0; i < 44; i++) random_item();
    end
  endtask

  // receiver stall pattern and long hold-off
  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_cnt = HoldCycles;
      hold_req = 1'b0;
    end
    if (hold_cnt != 0) begin
      out_ready_i <= 1'b0;
      hold_cnt--;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // result checker
  always @(posedge clk_i) begin : result_check
    alloc_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_q.size() == 0) begin
        $display("unexpected result transfer at %0t", $realtime);
        err_cnt++;
      end else begin
        want = expected_q.pop_front();
        if (status_o !== want.status) report("status", status_o, want.status);
        if (user_offset_o !== want.user_offset)
          report("user_offset", user_offset_o, want.user_offset);
        if (granted_size_o !== want.granted_size)
          report("granted_size", granted_size_o, want.granted_size);
      end
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    err_cnt         = 0;
    cycle_cnt       = 0;
    burst_left      = 4;
    stall_pct       = 20;
    hold_cnt        = 0;
    hold_req        = 1'b0;
    rst_ni          = 1'b0;
    cfg_valid_i     = 1'b0;
    cfg_pool_size_i = '0;
    in_valid_i      = 1'b0;
    operation_i     = 1'b0;
    request_size_i  = '0;
    free_offset_i   = '0;
    out_ready_i     = 1'b0;
    pool_write(17'd65536);
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(negedge clk_i);

    test_reset_pool();
    test_extremes();
    test_pool_settings();
    test_backpressure();
    test_random();

    drain();
    repeat (50) @(negedge clk_i);
    if (err_cnt == 0 && expected_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
